// ===== rtl/letter_and_pair_histogram_defines.svh =====
// assertion macros for the letter and pair histogram
`ifndef LETTER_AND_PAIR_HISTOGRAM_DEFINES_SVH
`define LETTER_AND_PAIR_HISTOGRAM_DEFINES_SVH

// same-cycle implication, checked out of reset
`define LPH_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("same-cycle check failed");

// next-cycle implication, checked out of reset
`define LPH_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

// ===== rtl/lph_pkg.sv =====
// types and constants shared by the letter and pair histogram
package lph_pkg;

  localparam int BYTE_W          = 8;
  localparam int PAIR_ADDR_W     = 2 * BYTE_W;
  localparam int LETTER_DEPTH    = 1 << BYTE_W;
  localparam int PAIR_DEPTH      = 1 << PAIR_ADDR_W;
  localparam int COUNT_OUT_WIDTH = 32;
  localparam int QUEUE_DEPTH     = 4;
  localparam int QUEUE_PTR_W     = $clog2(QUEUE_DEPTH);
  localparam int QUEUE_CNT_W     = $clog2(QUEUE_DEPTH + 1);

  localparam logic [1:0] OP_FEED        = 2'd0;
  localparam logic [1:0] OP_READ_LETTER = 2'd1;
  localparam logic [1:0] OP_READ_PAIR   = 2'd2;
  localparam logic [1:0] OP_NONE        = 2'd3;

  localparam logic [BYTE_W-1:0] CHAR_UPPER_A = 8'h41;
  localparam logic [BYTE_W-1:0] CHAR_UPPER_Z = 8'h5a;
  localparam logic [BYTE_W-1:0] CHAR_LOWER_A = 8'h61;
  localparam logic [BYTE_W-1:0] CHAR_LOWER_Z = 8'h7a;
  localparam logic [BYTE_W-1:0] CASE_OFFSET  = 8'h20;

  typedef struct packed {
    logic [1:0]        opcode;
    logic [BYTE_W-1:0] char_byte;
    logic [BYTE_W-1:0] second_byte;
    logic              text_end;
  } in_item_t;

  typedef struct packed {
    logic [COUNT_OUT_WIDTH-1:0] count_value;
    logic                       is_pair;
  } out_item_t;

  typedef enum logic [1:0] {
    CMD_FEED,
    CMD_READ_LETTER,
    CMD_READ_PAIR
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t              kind;
    logic                   letter_en;
    logic                   pair_en;
    logic [BYTE_W-1:0]      letter_addr;
    logic [PAIR_ADDR_W-1:0] pair_addr;
  } cmd_t;

  typedef struct packed {
    logic full;
    logic not_empty;
  } q_status_t;

  typedef enum logic [1:0] {
    B_CLEAR,
    B_IDLE,
    B_UPDATE
  } back_state_t;

endpackage

// ===== rtl/letter_and_pair_histogram.sv =====
// top level of the letter and pair histogram
//
//  channel  | direction | handshake                  | payload
//  item     | in        | item_valid / item_stall     | lph_pkg::in_item_t
//  result   | out       | result_valid / result_stall | lph_pkg::out_item_t
//  cfg      | in        | cfg_we                      | cfg_wdata (fold_case)
//
// the front takes one item per cycle until the four-entry command queue fills or a clearing pass runs
// the back handles each command as a queue pop with table read, then an update, and pops no new one before that
// after reset a clearing pass zeroes both count tables while item_stall is high
// feeds of non-letters with no predecessor and unused opcodes take only the front
// a read result waits in the output register while result_stall is high
`include "letter_and_pair_histogram_defines.svh"

module letter_and_pair_histogram #(
  parameter int COUNT_WIDTH = 32
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  logic               cfg_wdata,
  input  lph_pkg::in_item_t  item,
  input  logic               item_valid,
  output logic               item_stall,
  output lph_pkg::out_item_t result,
  output logic               result_valid,
  input  logic               result_stall
);

  import lph_pkg::*;

  logic      push;
  cmd_t      push_cmd;
  logic      pop;
  cmd_t      head;
  q_status_t q_status;
  logic      clearing;

  lph_front u_front (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .item       (item),
    .item_valid (item_valid),
    .item_stall (item_stall),
    .clearing   (clearing),
    .q_status   (q_status),
    .push       (push),
    .push_cmd   (push_cmd)
  );

  lph_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_cmd (push_cmd),
    .pop      (pop),
    .head     (head),
    .q_status (q_status)
  );

  lph_back #(
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_back (
    .clk          (clk),
    .rst          (rst),
    .head         (head),
    .q_status     (q_status),
    .pop          (pop),
    .clearing     (clearing),
    .result       (result),
    .result_valid (result_valid),
    .result_stall (result_stall)
  );

  `LPH_ASSERT_NOW(a_no_overflow, push, !q_status.full)
  `LPH_ASSERT_NOW(a_no_pop_in_clear, clearing, !pop && !push)
  `LPH_ASSERT_NOW(a_unused_op_silent, item_valid && !item_stall && item.opcode == OP_NONE, !push)
  `LPH_ASSERT_NEXT(a_pop_then_busy, pop, !pop)

endmodule

// ===== rtl/lph_ram.sv =====
// generic single-port-write, single-port-read ram with registered read
module lph_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== rtl/lph_front.sv =====
// front end: accepts items, folds case, tracks the predecessor byte and builds commands
module lph_front (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_we,
  input  logic                cfg_wdata,
  input  lph_pkg::in_item_t   item,
  input  logic                item_valid,
  output logic                item_stall,
  input  logic                clearing,
  input  lph_pkg::q_status_t  q_status,
  output logic                push,
  output lph_pkg::cmd_t       push_cmd
);

  import lph_pkg::*;

  logic              fold_case;
  logic [BYTE_W-1:0] previous_byte;
  logic              have_previous;

  logic              accept;
  logic [BYTE_W-1:0] folded;
  logic              is_letter;

  assign item_stall = q_status.full || clearing;
  assign accept     = item_valid && !item_stall;

  always_comb begin
    folded = item.char_byte;
    if (fold_case && (item.char_byte inside {[CHAR_UPPER_A:CHAR_UPPER_Z]})) begin
      folded = item.char_byte + CASE_OFFSET;
    end
    is_letter = folded inside {[CHAR_LOWER_A:CHAR_LOWER_Z]};
  end

  always_comb begin
    push_cmd = '{kind: CMD_FEED, letter_en: 1'b0, pair_en: 1'b0,
                 letter_addr: folded, pair_addr: {previous_byte, folded}};
    push     = 1'b0;
    case (item.opcode)
      OP_FEED: begin
        push_cmd.letter_en = is_letter;
        push_cmd.pair_en   = have_previous;
        push               = accept && (is_letter || have_previous);
      end
      OP_READ_LETTER: begin
        push_cmd.kind        = CMD_READ_LETTER;
        push_cmd.letter_addr = item.char_byte;
        push                 = accept;
      end
      OP_READ_PAIR: begin
        push_cmd.kind      = CMD_READ_PAIR;
        push_cmd.pair_addr = {item.char_byte, item.second_byte};
        push               = accept;
      end
      default: begin
        push = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fold_case     <= 1'b1;
      previous_byte <= '0;
      have_previous <= 1'b0;
    end else begin
      if (cfg_we) begin
        fold_case <= cfg_wdata;
      end
      if (accept && item.opcode == OP_FEED) begin
        previous_byte <= folded;
        have_previous <= !item.text_end;
      end
    end
  end

endmodule

// ===== rtl/lph_queue.sv =====
// short command queue between front and back
module lph_queue (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  input  lph_pkg::cmd_t      push_cmd,
  input  logic               pop,
  output lph_pkg::cmd_t      head,
  output lph_pkg::q_status_t q_status
);

  import lph_pkg::*;

  cmd_t                   entries [QUEUE_DEPTH];
  logic [QUEUE_PTR_W-1:0] wr_ptr;
  logic [QUEUE_PTR_W-1:0] rd_ptr;
  logic [QUEUE_CNT_W-1:0] fill;

  assign head               = entries[rd_ptr];
  assign q_status.full      = fill == QUEUE_CNT_W'(QUEUE_DEPTH);
  assign q_status.not_empty = fill != '0;

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   fill <= fill + 1'b1;
        2'b01:   fill <= fill - 1'b1;
        default: fill <= fill;
      endcase
    end
  end

endmodule

// ===== rtl/lph_back.sv =====
// back end: clearing pass, table read-modify-write and result register
module lph_back #(
  parameter int COUNT_WIDTH = 32
) (
  input  logic               clk,
  input  logic               rst,
  input  lph_pkg::cmd_t      head,
  input  lph_pkg::q_status_t q_status,
  output logic               pop,
  output logic               clearing,
  output lph_pkg::out_item_t result,
  output logic               result_valid,
  input  logic               result_stall
);

  import lph_pkg::*;

  back_state_t            state;
  back_state_t            state_next;
  logic [PAIR_ADDR_W-1:0] clear_addr;
  logic [PAIR_ADDR_W-1:0] clear_addr_next;
  cmd_t                   cmd;

  logic                   out_free;
  logic                   load_out;
  logic                   letter_we;
  logic [BYTE_W-1:0]      letter_wr_addr;
  logic [COUNT_WIDTH-1:0] letter_wr_data;
  logic [COUNT_WIDTH-1:0] letter_rd;
  logic                   pair_we;
  logic [PAIR_ADDR_W-1:0] pair_wr_addr;
  logic [COUNT_WIDTH-1:0] pair_wr_data;
  logic [COUNT_WIDTH-1:0] pair_rd;
  logic [COUNT_WIDTH-1:0] sel_count;
  logic [COUNT_OUT_WIDTH-1:0] clipped;

  assign out_free = !result_valid || !result_stall;

  always_comb begin
    state_next      = state;
    clear_addr_next = clear_addr;
    case (state)
      B_CLEAR: begin
        clear_addr_next = clear_addr + 1'b1;
        if (clear_addr == '1) begin
          state_next = B_IDLE;
        end
      end
      B_IDLE: begin
        if (q_status.not_empty) begin
          state_next = B_UPDATE;
        end
      end
      B_UPDATE: begin
        case (cmd.kind)
          CMD_READ_LETTER, CMD_READ_PAIR: begin
            if (out_free) begin
              state_next = B_IDLE;
            end
          end
          default: begin
            state_next = B_IDLE;
          end
        endcase
      end
      default: begin
        state_next = B_CLEAR;
      end
    endcase
  end

  always_comb begin
    clearing       = state == B_CLEAR;
    pop            = state == B_IDLE && q_status.not_empty;
    load_out       = 1'b0;
    letter_we      = 1'b0;
    pair_we        = 1'b0;
    letter_wr_addr = cmd.letter_addr;
    pair_wr_addr   = cmd.pair_addr;
    letter_wr_data = (letter_rd == '1) ? letter_rd : letter_rd + 1'b1;
    pair_wr_data   = (pair_rd == '1) ? pair_rd : pair_rd + 1'b1;
    case (state)
      B_CLEAR: begin
        letter_we      = 1'b1;
        pair_we        = 1'b1;
        letter_wr_addr = clear_addr[BYTE_W-1:0];
        pair_wr_addr   = clear_addr;
        letter_wr_data = '0;
        pair_wr_data   = '0;
      end
      B_UPDATE: begin
        case (cmd.kind)
          CMD_READ_LETTER, CMD_READ_PAIR: begin
            load_out = out_free;
          end
          default: begin
            letter_we = cmd.letter_en;
            pair_we   = cmd.pair_en;
          end
        endcase
      end
      default: begin
        load_out = 1'b0;
      end
    endcase
  end

  lph_ram #(
    .WIDTH (COUNT_WIDTH),
    .DEPTH (LETTER_DEPTH)
  ) u_letter_ram (
    .clk     (clk),
    .we      (letter_we),
    .wr_addr (letter_wr_addr),
    .wr_data (letter_wr_data),
    .rd_en   (pop),
    .rd_addr (head.letter_addr),
    .rd_data (letter_rd)
  );

  lph_ram #(
    .WIDTH (COUNT_WIDTH),
    .DEPTH (PAIR_DEPTH)
  ) u_pair_ram (
    .clk     (clk),
    .we      (pair_we),
    .wr_addr (pair_wr_addr),
    .wr_data (pair_wr_data),
    .rd_en   (pop),
    .rd_addr (head.pair_addr),
    .rd_data (pair_rd)
  );

  assign sel_count = (cmd.kind == CMD_READ_PAIR) ? pair_rd : letter_rd;

  generate
    if (COUNT_WIDTH > COUNT_OUT_WIDTH) begin : g_clip
      assign clipped = (|sel_count[COUNT_WIDTH-1:COUNT_OUT_WIDTH]) ? '1
                                                               : sel_count[COUNT_OUT_WIDTH-1:0];
    end else begin : g_extend
      assign clipped = COUNT_OUT_WIDTH'(sel_count);
    end
  endgenerate

  always_ff @(posedge clk) begin
    if (pop) begin
      cmd <= head;
    end
    if (load_out) begin
      result.count_value <= clipped;
      result.is_pair     <= cmd.kind == CMD_READ_PAIR;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= B_CLEAR;
      clear_addr   <= '0;
      result_valid <= 1'b0;
    end else begin
      state      <= state_next;
      clear_addr <= clear_addr_next;
      if (load_out) begin
        result_valid <= 1'b1;
      end else if (!result_stall) begin
        result_valid <= 1'b0;
      end
    end
  end

endmodule
